### sv/pae_pkg.sv
// shared constants and types of the positional array editor
package pae_pkg;

    localparam int DEPTH   = 32;
    localparam int MAX_OUT = 32;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CW      = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [2:0] {
        MODE_APPEND  = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_REVERSE = 3'd3,
        MODE_DISPLAY = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // what a cell loads at the next edge
    typedef enum logic [2:0] {
        SEL_HOLD  = 3'd0,
        SEL_VALUE = 3'd1,
        SEL_LOWER = 3'd2,
        SEL_UPPER = 3'd3,
        SEL_HEAD  = 3'd4
    } sel_t;

endpackage

### sv/pae_cell.sv
// one storage cell of the entry chain
module pae_cell (
    input  logic                               clk,
    input  pae_pkg::sel_t                      sel,
    input  logic signed [pae_pkg::WORD_W-1:0]  value,
    input  logic signed [pae_pkg::WORD_W-1:0]  lower,
    input  logic signed [pae_pkg::WORD_W-1:0]  upper,
    input  logic signed [pae_pkg::WORD_W-1:0]  head,
    output logic signed [pae_pkg::WORD_W-1:0]  q
);
    import pae_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        case (sel)
            SEL_VALUE: data_next = value;
            SEL_LOWER: data_next = lower;
            SEL_UPPER: data_next = upper;
            SEL_HEAD:  data_next = head;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### sv/positional_array_editor.sv
// top level: chain of entry cells with the operation sequencer
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | mode, position, value
//  out     | out       | out_valid/out_stall | status, data, fill_count, last
//
// append, insert, delete and unused modes complete on acceptance: every cell shifts at once
// reverse then rotates the head into the chain, step by step, behind a shrinking prefix
// display then emits count beats, one beat per cycle, each waiting on out_stall
// reset clears the count; entry contents stay undefined until written
// in_stall is high while a reverse or display runs or the output beat is stuck
module positional_array_editor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         mode,
    input  logic [4:0]                         position,
    input  logic signed [pae_pkg::WORD_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [pae_pkg::WORD_W-1:0]  data,
    output logic [5:0]                         fill_count,
    output logic                               last
);
    import pae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_REV  = 3'b010,
        S_DISP = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       step_reg, step_next;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic signed [WORD_W-1:0] data_reg;
    logic [5:0]             fill_reg;
    logic                   last_reg;

    logic                   load_out;
    status_t                o_status;
    logic signed [WORD_W-1:0] o_data;
    logic                   o_last;

    sel_t                   sel [DEPTH];
    logic signed [WORD_W-1:0] cell_q [DEPTH];

    logic                   out_free;
    logic                   accept;
    logic [CW-1:0]          cnt_x, pos_x, step_x, n_emit;
    logic                   emit_now;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign cnt_x  = CW'(count_reg);
    assign pos_x  = CW'(position);
    assign step_x = CW'(step_reg);
    assign n_emit = (cnt_x < CW'(MAX_OUT)) ? cnt_x : CW'(MAX_OUT);
    assign emit_now = step_x < CW'(MAX_OUT);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        load_out   = 1'b0;
        o_status   = ST_OK;
        o_data     = '0;
        o_last     = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel[i] = SEL_HOLD;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (mode)
                        MODE_APPEND:
                        begin
                            if (cnt_x >= CW'(DEPTH))
                            begin
                                o_status = ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CW'(i) == cnt_x)
                                        sel[i] = SEL_VALUE;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                o_status = ST_BADPOS;
                            end
                            else if (cnt_x >= CW'(DEPTH))
                            begin
                                o_status = ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CW'(i) == pos_x)
                                        sel[i] = SEL_VALUE;
                                    else if (CW'(i) > pos_x && CW'(i) <= cnt_x)
                                        sel[i] = SEL_LOWER;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                o_status = ST_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CW'(i) >= pos_x && CW'(i) + 1'b1 < cnt_x)
                                        sel[i] = SEL_UPPER;
                                end
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (cnt_x >= CW'(2))
                            begin
                                state_next = S_REV;
                                step_next  = count_reg - 1'b1;
                            end
                        end
                        MODE_DISPLAY:
                        begin
                            if (cnt_x == '0)
                            begin
                                o_status = ST_EMPTY;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                state_next = S_DISP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            o_status = ST_OK;
                        end
                    endcase
                end
            end
            S_REV:
            begin
                // pull the head out and drop it in behind the shrinking prefix
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (CW'(i) < step_x)
                        sel[i] = SEL_UPPER;
                    else if (CW'(i) == step_x)
                        sel[i] = SEL_HEAD;
                end
                step_next = step_reg - 1'b1;
                if (step_x == CW'(1))
                    state_next = S_IDLE;
            end
            S_DISP:
            begin
                // rotate the filled part once per beat, reading at the head
                if (!emit_now || out_free)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CW'(i) + 1'b1 < cnt_x)
                            sel[i] = SEL_UPPER;
                        else if (CW'(i) + 1'b1 == cnt_x)
                            sel[i] = SEL_HEAD;
                    end
                    if (emit_now)
                    begin
                        load_out = 1'b1;
                        o_data   = cell_q[0];
                        o_last   = (step_x + 1'b1 == n_emit);
                    end
                    step_next = step_reg + 1'b1;
                    if (step_x + 1'b1 == cnt_x)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] lower_in;
        logic signed [WORD_W-1:0] upper_in;
        if (g == 0)
        begin : g_first
            assign lower_in = '0;
        end
        else
        begin : g_mid_lo
            assign lower_in = cell_q[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_final
            assign upper_in = '0;
        end
        else
        begin : g_mid_hi
            assign upper_in = cell_q[g+1];
        end
        pae_cell u_cell (
            .clk   (clk),
            .sel   (sel[g]),
            .value (value),
            .lower (lower_in),
            .upper (upper_in),
            .head  (cell_q[0]),
            .q     (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= o_status;
            data_reg   <= o_data;
            fill_reg   <= 6'(count_next);
            last_reg   <= o_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data       = data_reg;
    assign fill_count = fill_reg;
    assign last       = last_reg;

endmodule

### sv/pae_checker.sv
// port-level checks of the positional array editor, bound to the top level
module pae_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [1:0]                         status,
    input logic signed [pae_pkg::WORD_W-1:0]  data,
    input logic [5:0]                         fill_count,
    input logic                               last
);
    import pae_pkg::*;

    // stalled beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
            && $stable(fill_count) && $stable(last))
        else $error("output beat changed while stalled");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count <= 6'(DEPTH))
        else $error("fill count beyond depth");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> data == '0 && last)
        else $error("refused operation carries data or is not last");

    a_empty_disp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill_count == '0)
        else $error("empty status with nonzero count");

    a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_OK && fill_count != '0)
        else $error("non-final beat outside a display");

endmodule

bind positional_array_editor pae_checker u_pae_checker (.*);
